// File: sv/tvvd_pkg.sv
// Shared types and constants for the tagged varint value decoder.
`timescale 1ns / 1ps

package tvvd_pkg;

    localparam logic [15:0] INT_COLUMN_CODE  = 16'd20;
    localparam logic [3:0]  MAX_VARINT_BYTES = 4'd10;
    localparam logic [3:0]  LAST_INT_INDEX   = 4'd9;
    localparam logic [3:0]  NULL_VALUE_TYPE  = 4'd1;
    localparam logic [6:0]  GROUP_MASK       = 7'h7f;
    localparam logic [3:0]  TYPE_MASK        = 4'hf;

    typedef enum logic [2:0] {
        ST_INT         = 3'd0,
        ST_NULL        = 3'd1,
        ST_UNSUPPORTED = 3'd2,
        ST_OVERFLOW    = 3'd3,
        ST_TAG_LONG    = 3'd4
    } status_t;

    typedef struct packed {
        logic [15:0] column_type;
        logic [7:0]  data_byte;
    } in_item_t;

    typedef struct packed {
        status_t     status;
        logic [31:0] column_id;
        logic [3:0]  value_type;
        logic [3:0]  tag_length;
        logic [63:0] int_value;
    } result_t;

endpackage

// File: sv/tvvd_in_stage.sv
// Input register stage: holds one accepted byte until the decoder consumes it.
`timescale 1ns / 1ps

module tvvd_in_stage (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  tvvd_pkg::in_item_t s_item,
    input  logic              pop,
    output logic              item_valid,
    output tvvd_pkg::in_item_t item
);
    import tvvd_pkg::*;

    logic     valid_reg;
    logic     valid_next;
    in_item_t item_reg;

    // The register can take a new transfer whenever it is empty or drains this cycle.
    assign s_tready   = !valid_reg || pop;
    assign valid_next = (s_tvalid && s_tready) ? 1'b1 : (pop ? 1'b0 : valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            item_reg <= s_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

// File: sv/tvvd_core.sv
// Decoder state and the per-byte next-state and result logic.
`timescale 1ns / 1ps

module tvvd_core (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               take,
    input  tvvd_pkg::in_item_t item,
    output logic               res_valid,
    output tvvd_pkg::result_t  res
);
    import tvvd_pkg::*;

    logic        phase_reg,   phase_next;
    logic [63:0] acc_reg,     acc_next;
    logic [3:0]  idx_reg,     idx_next;
    logic [31:0] cid_reg,     cid_next;
    logic [3:0]  vtype_reg,   vtype_next;
    logic [3:0]  tlen_reg,    tlen_next;
    logic        is_int_reg,  is_int_next;

    logic [7:0]  b;
    logic [63:0] acc_shift;
    logic [63:0] acc_or;
    logic [3:0]  idx_inc;
    logic [6:0]  shamt;
    logic [31:0] tag_cid;
    logic [3:0]  tag_vtype;

    assign b         = item.data_byte;
    assign acc_shift = {acc_reg[56:0], b[6:0] & GROUP_MASK};
    assign idx_inc   = idx_reg + 4'd1;
    // Shift of the group within the little-endian integer: seven bits per byte.
    assign shamt     = {idx_reg, 3'b000} - {3'b000, idx_reg};
    assign acc_or    = acc_reg | ({57'd0, b[6:0]} << shamt);
    assign tag_cid   = acc_shift[35:4];
    assign tag_vtype = acc_shift[3:0] & TYPE_MASK;

    always_comb begin
        phase_next  = phase_reg;
        acc_next    = acc_reg;
        idx_next    = idx_reg;
        cid_next    = cid_reg;
        vtype_next  = vtype_reg;
        tlen_next   = tlen_reg;
        is_int_next = is_int_reg;
        res_valid   = 1'b0;
        res         = '{status: ST_INT, column_id: 32'd0, value_type: 4'd0,
                        tag_length: 4'd0, int_value: 64'd0};

        if (take) begin
            if (!phase_reg) begin
                if (idx_reg == 4'd0) begin
                    is_int_next = (item.column_type == INT_COLUMN_CODE);
                end
                if (b[7]) begin
                    if (idx_inc >= MAX_VARINT_BYTES) begin
                        acc_next       = 64'd0;
                        idx_next       = 4'd0;
                        res_valid      = 1'b1;
                        res.status     = ST_TAG_LONG;
                        res.tag_length = MAX_VARINT_BYTES;
                    end else begin
                        acc_next = acc_shift;
                        idx_next = idx_inc;
                    end
                end else begin
                    cid_next       = tag_cid;
                    vtype_next     = tag_vtype;
                    tlen_next      = idx_inc;
                    res.column_id  = tag_cid;
                    res.value_type = tag_vtype;
                    res.tag_length = idx_inc;
                    acc_next       = 64'd0;
                    idx_next       = 4'd0;
                    if (tag_vtype == NULL_VALUE_TYPE) begin
                        res_valid  = 1'b1;
                        res.status = ST_NULL;
                    end else if (!is_int_next) begin
                        res_valid  = 1'b1;
                        res.status = ST_UNSUPPORTED;
                    end else begin
                        phase_next = 1'b1;
                    end
                end
            end else begin
                res.column_id  = cid_reg;
                res.value_type = vtype_reg;
                res.tag_length = tlen_reg;
                if (idx_reg >= LAST_INT_INDEX && b > 8'd1) begin
                    phase_next = 1'b0;
                    acc_next   = 64'd0;
                    idx_next   = 4'd0;
                    res_valid  = 1'b1;
                    res.status = ST_OVERFLOW;
                end else if (b[7]) begin
                    acc_next = acc_or;
                    idx_next = idx_inc;
                end else begin
                    phase_next    = 1'b0;
                    acc_next      = 64'd0;
                    idx_next      = 4'd0;
                    res_valid     = 1'b1;
                    res.status    = ST_INT;
                    // Undo the zigzag mapping: even codes are positive, odd ones negative.
                    res.int_value = {1'b0, acc_or[63:1]} ^ {64{acc_or[0]}};
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= 1'b0;
            acc_reg    <= 64'd0;
            idx_reg    <= 4'd0;
            cid_reg    <= 32'd0;
            vtype_reg  <= 4'd0;
            tlen_reg   <= 4'd0;
            is_int_reg <= 1'b0;
        end else begin
            phase_reg  <= phase_next;
            acc_reg    <= acc_next;
            idx_reg    <= idx_next;
            cid_reg    <= cid_next;
            vtype_reg  <= vtype_next;
            tlen_reg   <= tlen_next;
            is_int_reg <= is_int_next;
        end
    end

endmodule

// File: sv/tvvd_out_stage.sv
// Result register: holds one decoded result until the receiver takes it.
`timescale 1ns / 1ps

module tvvd_out_stage (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              res_valid,
    input  tvvd_pkg::result_t res,
    output logic              room,
    output logic              m_tvalid,
    input  logic              m_tready,
    output tvvd_pkg::result_t m_res
);
    import tvvd_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    result_t res_reg;

    // A new result may be written when the register is empty or is being emptied now.
    assign room       = !valid_reg || m_tready;
    assign valid_next = res_valid ? 1'b1 : (m_tready ? 1'b0 : valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid) begin
            res_reg <= res;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_res    = res_reg;

endmodule

// File: sv/tagged_varint_value_decoder.sv
// Top level of the tagged varint value decoder.
`timescale 1ns / 1ps
//
// Usage:
//   The s_ channel carries the encoded stream one byte per transfer; tuser
//   carries the column type code, which only matters on a value's first byte.
//   Each value is a big-endian tag varint (type in bits 3:0, column id above)
//   followed, for integer columns, by a little-endian zigzag varint.
//   The m_ channel gives one transfer per finished value: an integer, a null,
//   an unsupported-type marker, an integer overflow or a tag that ran too long.
//   Bytes that do not finish a value give no transfer.
// Timing:
//   A byte goes into an input register, is decoded from there and its result
//   lands in the output register, which drives m_tvalid. One byte per cycle is
//   sustained while m_tready keeps the output register free; the decode loop
//   over the tag and integer accumulators sets that rate.
// Reset:
//   aresetn empties both registers and clears the decoder, which then waits for a tag.
// Backpressure:
//   While m_tready is low and a result is held, the input register still holds
//   one byte; s_tready drops once that byte is waiting on the full result.
//
module tagged_varint_value_decoder (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,   // [7:0] data_byte
    input  logic [15:0]  s_tuser,   // [15:0] column_type
    output logic         m_tvalid,
    input  logic         m_tready,
    // [31:0] column_id, [35:32] value_type, [39:36] tag_length, [103:40] int_value
    output logic [103:0] m_tdata,
    output logic [2:0]   m_tuser    // [2:0] status
);
    import tvvd_pkg::*;

    in_item_t s_item;
    in_item_t item;
    logic     item_valid;
    logic     room;
    logic     take;
    logic     res_valid;
    result_t  res;
    result_t  m_res;

    assign s_item = '{column_type: s_tuser, data_byte: s_tdata};
    assign take   = item_valid && room;

    tvvd_in_stage u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_item     (s_item),
        .pop        (take),
        .item_valid (item_valid),
        .item       (item)
    );

    tvvd_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .take      (take),
        .item      (item),
        .res_valid (res_valid),
        .res       (res)
    );

    tvvd_out_stage u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .res_valid (res_valid),
        .res       (res),
        .room      (room),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_res     (m_res)
    );

    assign m_tuser = m_res.status;
    assign m_tdata = {m_res.int_value, m_res.tag_length, m_res.value_type, m_res.column_id};

`ifndef SYNTHESIS
    a_stall_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        (item_valid && m_tvalid && !m_tready) |-> !s_tready)
        else $error("input accepted while a waiting byte is blocked by a full result");

    a_value_only_for_int: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser != ST_INT) |-> (m_tdata[103:40] == 64'd0))
        else $error("nonzero integer value on a non-integer result");

    a_tag_long_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser == ST_TAG_LONG) |->
        (m_tdata[39:36] == MAX_VARINT_BYTES && m_tdata[35:0] == 36'd0))
        else $error("malformed tag-too-long result");

    a_tag_length_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[39:36] != 4'd0 && m_tdata[39:36] <= MAX_VARINT_BYTES))
        else $error("tag length out of range");
`endif

endmodule
